/* rtl/assert_macros.svh */
// Assertion macros used by the top-level RTL file of the quadratic solver.
// Depends on nothing; the top-level form expects clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_TOP(lbl, prop, msg) `ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)
`endif

/* rtl/qes_pkg.sv */
// Package of the quadratic solver: step counts, solution classes and the
// sideband types that ride along the root and divider pipelines. No dependencies.
`default_nettype none
package qes_pkg;
  localparam int SqrtSteps = 25;
  localparam int DivSteps = 35;

  typedef enum logic [1:0] {
    CLS_INF  = 2'd0,
    CLS_NONE = 2'd1,
    CLS_ONE  = 2'd2,
    CLS_TWO  = 2'd3
  } cls_e;

  typedef struct packed {
    logic signed [15:0] a;
    logic signed [15:0] b;
    logic signed [15:0] c;
    cls_e cls;
  } isq_side_t;

  typedef struct packed {
    cls_e cls;
    logic neg1;
    logic neg2;
  } div_side_t;
endpackage
`default_nettype wire

/* rtl/qes_isqrt.sv */
// Pipelined floor square root of a 50-bit radicand, one result bit per stage.
// Depends on qes_pkg for the stage count and the sideband type.
`default_nettype none
module qes_isqrt (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [49:0]         rad_i,
  input  qes_pkg::isq_side_t  side_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [24:0]         root_o,
  output qes_pkg::isq_side_t  side_o
);
  typedef struct packed {
    logic [25:0]        rem;
    logic [24:0]        root;
    logic [49:0]        rad;
    qes_pkg::isq_side_t side;
  } isq_st_t;

  function automatic isq_st_t isq_step(isq_st_t s);
    isq_st_t     r;
    logic [27:0] rm;
    logic [27:0] trial;
    r = s;
    rm = {s.rem, s.rad[49:48]};
    trial = {1'b0, s.root, 2'b01};
    if (rm >= trial) begin
      r.rem = 26'(rm - trial);
      r.root = {s.root[23:0], 1'b1};
    end else begin
      r.rem = rm[25:0];
      r.root = {s.root[23:0], 1'b0};
    end
    r.rad = {s.rad[47:0], 2'b00};
    return r;
  endfunction

  isq_st_t st_q [qes_pkg::SqrtSteps];
  isq_st_t st_in [qes_pkg::SqrtSteps];
  logic    vld_q [qes_pkg::SqrtSteps];
  logic    v_in [qes_pkg::SqrtSteps];
  logic    rdy [qes_pkg::SqrtSteps+1];

  assign rdy[qes_pkg::SqrtSteps] = out_ready_i;

  for (genvar i = 0; i < qes_pkg::SqrtSteps; i++) begin : g_stage
    if (i == 0) begin : g_first
      assign st_in[i] = '{rem: '0, root: '0, rad: rad_i, side: side_i};
      assign v_in[i] = in_valid_i;
    end else begin : g_next
      assign st_in[i] = st_q[i-1];
      assign v_in[i] = vld_q[i-1];
    end
    assign rdy[i] = !vld_q[i] || rdy[i+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (rdy[i]) begin
        vld_q[i] <= v_in[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[i] && v_in[i]) begin
        st_q[i] <= isq_step(st_in[i]);
      end
    end
  end

  assign in_ready_o = rdy[0];
  assign out_valid_o = vld_q[qes_pkg::SqrtSteps-1];
  assign root_o = st_q[qes_pkg::SqrtSteps-1].root;
  assign side_o = st_q[qes_pkg::SqrtSteps-1].side;
endmodule
`default_nettype wire

/* rtl/qes_div2.sv */
// Two-lane pipelined restoring divider on magnitudes, one quotient bit per stage.
// Depends on qes_pkg for the stage count and the sideband type.
`default_nettype none
module qes_div2 (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [34:0]         num1_i,
  input  logic [16:0]         den1_i,
  input  logic [34:0]         num2_i,
  input  logic [16:0]         den2_i,
  input  qes_pkg::div_side_t  side_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [34:0]         quo1_o,
  output logic [34:0]         quo2_o,
  output qes_pkg::div_side_t  side_o
);
  typedef struct packed {
    logic [16:0]        rem1;
    logic [34:0]        nq1;
    logic [16:0]        den1;
    logic [16:0]        rem2;
    logic [34:0]        nq2;
    logic [16:0]        den2;
    qes_pkg::div_side_t side;
  } div_st_t;

  function automatic div_st_t div_step(div_st_t s);
    div_st_t     r;
    logic [17:0] rm1;
    logic [17:0] rm2;
    r = s;
    rm1 = {s.rem1, s.nq1[34]};
    rm2 = {s.rem2, s.nq2[34]};
    if (rm1 >= {1'b0, s.den1}) begin
      r.rem1 = 17'(rm1 - {1'b0, s.den1});
      r.nq1 = {s.nq1[33:0], 1'b1};
    end else begin
      r.rem1 = rm1[16:0];
      r.nq1 = {s.nq1[33:0], 1'b0};
    end
    if (rm2 >= {1'b0, s.den2}) begin
      r.rem2 = 17'(rm2 - {1'b0, s.den2});
      r.nq2 = {s.nq2[33:0], 1'b1};
    end else begin
      r.rem2 = rm2[16:0];
      r.nq2 = {s.nq2[33:0], 1'b0};
    end
    return r;
  endfunction

  div_st_t st_q [qes_pkg::DivSteps];
  div_st_t st_in [qes_pkg::DivSteps];
  logic    vld_q [qes_pkg::DivSteps];
  logic    v_in [qes_pkg::DivSteps];
  logic    rdy [qes_pkg::DivSteps+1];

  assign rdy[qes_pkg::DivSteps] = out_ready_i;

  for (genvar i = 0; i < qes_pkg::DivSteps; i++) begin : g_stage
    if (i == 0) begin : g_first
      assign st_in[i] = '{rem1: '0, nq1: num1_i, den1: den1_i,
                          rem2: '0, nq2: num2_i, den2: den2_i, side: side_i};
      assign v_in[i] = in_valid_i;
    end else begin : g_next
      assign st_in[i] = st_q[i-1];
      assign v_in[i] = vld_q[i-1];
    end
    assign rdy[i] = !vld_q[i] || rdy[i+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (rdy[i]) begin
        vld_q[i] <= v_in[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[i] && v_in[i]) begin
        st_q[i] <= div_step(st_in[i]);
      end
    end
  end

  assign in_ready_o = rdy[0];
  assign out_valid_o = vld_q[qes_pkg::DivSteps-1];
  assign quo1_o = st_q[qes_pkg::DivSteps-1].nq1;
  assign quo2_o = st_q[qes_pkg::DivSteps-1].nq2;
  assign side_o = st_q[qes_pkg::DivSteps-1].side;
endmodule
`default_nettype wire

/* rtl/quadratic_equation_solver.sv */
// Top level of the quadratic solver: input, product and discriminant stages,
// the square root and divider pipelines, and the clamping output register.
// Depends on qes_pkg, qes_isqrt, qes_div2 and assert_macros.svh.
//
// The solver accepts one coefficient word per cycle while the output side keeps
// up and returns one result word per coefficient word, in order, through
// three front stages, 25 square root stages (one root bit each),
// one numerator stage, 35 divider stages (one quotient bit each) and the output
// register. Each stage holds its word while the stage after it is full and held, so a
// stall on the output side fills empty stages first before input is refused.
`default_nettype none
`include "assert_macros.svh"
module quadratic_equation_solver (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // coef_quad [15:0], coef_lin [31:16], coef_const [47:32]
  input  logic [47:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // root_first [31:0], root_second [63:32]
  output logic [63:0] m_axis_tdata_o,
  // solution_class [1:0], saturated [2]
  output logic [2:0]  m_axis_tuser_o
);
  typedef struct packed {
    logic signed [15:0] c;
    logic signed [15:0] b;
    logic signed [15:0] a;
  } coef_t;

  typedef struct packed {
    logic [31:0] val;
    logic        sat;
  } clamp_t;

  function automatic clamp_t clamp_q(logic signed [36:0] v);
    clamp_t r;
    if (v[36:31] == 6'b000000 || v[36:31] == 6'b111111) begin
      r.val = v[31:0];
      r.sat = 1'b0;
    end else begin
      r.val = v[36] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      r.sat = 1'b1;
    end
    return r;
  endfunction

  logic               va_q, vb_q, vc_q, ve_q, vf_q;
  logic               rdy_a, rdy_b, rdy_c, rdy_e, rdy_f;
  coef_t              sa_q, sb_q;
  logic signed [31:0] bsq_q, ac_q;
  qes_pkg::isq_side_t side_c_q;
  logic [49:0]        rad_c_q;

  assign rdy_f = !vf_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else begin
      if (rdy_a) va_q <= s_axis_tvalid_i;
      if (rdy_b) vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a && s_axis_tvalid_i) begin
      sa_q <= s_axis_tdata_i;
    end
    if (rdy_b && va_q) begin
      sb_q <= sa_q;
      bsq_q <= sa_q.b * sa_q.b;
      ac_q <= sa_q.a * sa_q.c;
    end
  end

  assign rdy_a = !va_q || rdy_b;
  assign rdy_b = !vb_q || rdy_c;
  assign s_axis_tready_o = rdy_a;

  logic signed [34:0] disc;
  logic               a_zero;
  qes_pkg::cls_e      cls_c;

  always_comb begin
    disc = {{3{bsq_q[31]}}, bsq_q} - ({{3{ac_q[31]}}, ac_q} <<< 2);
    a_zero = (sb_q.a == 16'sd0);
    if (a_zero) begin
      if (sb_q.b != 16'sd0) cls_c = qes_pkg::CLS_ONE;
      else if (sb_q.c != 16'sd0) cls_c = qes_pkg::CLS_NONE;
      else cls_c = qes_pkg::CLS_INF;
    end else if (disc < 35'sd0) begin
      cls_c = qes_pkg::CLS_NONE;
    end else if (disc == 35'sd0) begin
      cls_c = qes_pkg::CLS_ONE;
    end else begin
      cls_c = qes_pkg::CLS_TWO;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else if (rdy_c) begin
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_c && vb_q) begin
      side_c_q <= '{a: sb_q.a, b: sb_q.b, c: sb_q.c, cls: cls_c};
      rad_c_q <= (disc > 35'sd0) ? {1'b0, disc[32:0], 16'h0000} : 50'd0;
    end
  end

  logic               isq_ready, isq_valid;
  logic [24:0]        isq_root;
  qes_pkg::isq_side_t isq_side;

  assign rdy_c = !vc_q || isq_ready;

  qes_isqrt u_isqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (vc_q),
    .in_ready_o  (isq_ready),
    .rad_i       (rad_c_q),
    .side_i      (side_c_q),
    .out_valid_o (isq_valid),
    .out_ready_i (rdy_e),
    .root_o      (isq_root),
    .side_o      (isq_side)
  );

  logic signed [34:0] nb, nc, n1, n2;
  logic signed [17:0] d1, d2;
  logic [34:0]        n1m_d, n2m_d;
  logic [17:0]        d1m_full, d2m_full;

  always_comb begin
    nb = -{{19{isq_side.b[15]}}, isq_side.b};
    nc = -{{19{isq_side.c[15]}}, isq_side.c};
    if (isq_side.a == 16'sd0) begin
      n1 = nc <<< 16;
      d1 = {{2{isq_side.b[15]}}, isq_side.b};
    end else begin
      n1 = ((nb <<< 8) + $signed({10'd0, isq_root})) <<< 8;
      d1 = {isq_side.a[15], isq_side.a, 1'b0};
    end
    n2 = nb <<< 16;
    d2 = {{2{isq_side.a[15]}}, isq_side.a};
    n1m_d = n1[34] ? 35'(-n1) : n1;
    n2m_d = n2[34] ? 35'(-n2) : n2;
    d1m_full = d1[17] ? 18'(-d1) : d1;
    d2m_full = d2[17] ? 18'(-d2) : d2;
  end

  logic [34:0]        n1m_q, n2m_q;
  logic [16:0]        d1m_q, d2m_q;
  qes_pkg::div_side_t dside_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ve_q <= 1'b0;
    end else if (rdy_e) begin
      ve_q <= isq_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_e && isq_valid) begin
      n1m_q <= n1m_d;
      n2m_q <= n2m_d;
      d1m_q <= d1m_full[16:0];
      d2m_q <= d2m_full[16:0];
      dside_q <= '{cls: isq_side.cls, neg1: n1[34] ^ d1[17], neg2: n2[34] ^ d2[17]};
    end
  end

  logic               div_ready, div_valid;
  logic [34:0]        quo1, quo2;
  qes_pkg::div_side_t div_side;

  assign rdy_e = !ve_q || div_ready;

  qes_div2 u_div2 (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (ve_q),
    .in_ready_o  (div_ready),
    .num1_i      (n1m_q),
    .den1_i      (d1m_q),
    .num2_i      (n2m_q),
    .den2_i      (d2m_q),
    .side_i      (dside_q),
    .out_valid_o (div_valid),
    .out_ready_i (rdy_f),
    .quo1_o      (quo1),
    .quo2_o      (quo2),
    .side_o      (div_side)
  );

  logic signed [35:0] q1s, q2s;
  logic signed [36:0] x2;
  clamp_t             c1, c2;
  logic [31:0]        r1_d, r2_d;
  logic               sat_d;

  always_comb begin
    q1s = div_side.neg1 ? 36'(-$signed({1'b0, quo1})) : $signed({1'b0, quo1});
    q2s = div_side.neg2 ? 36'(-$signed({1'b0, quo2})) : $signed({1'b0, quo2});
    x2 = {q2s[35], q2s} - {q1s[35], q1s};
    c1 = clamp_q({q1s[35], q1s});
    c2 = clamp_q(x2);
    case (div_side.cls)
      qes_pkg::CLS_ONE: begin
        r1_d = c1.val;
        r2_d = 32'd0;
        sat_d = c1.sat;
      end
      qes_pkg::CLS_TWO: begin
        r1_d = c1.val;
        r2_d = c2.val;
        sat_d = c1.sat || c2.sat;
      end
      default: begin
        r1_d = 32'd0;
        r2_d = 32'd0;
        sat_d = 1'b0;
      end
    endcase
  end

  logic [31:0]   r1_q, r2_q;
  logic          sat_q;
  qes_pkg::cls_e cls_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q <= 1'b0;
    end else if (rdy_f) begin
      vf_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_f && div_valid) begin
      r1_q <= r1_d;
      r2_q <= r2_d;
      sat_q <= sat_d;
      cls_q <= div_side.cls;
    end
  end

  assign m_axis_tvalid_o = vf_q;
  assign m_axis_tdata_o = {r2_q, r1_q};
  assign m_axis_tuser_o = {sat_q, cls_q};

  `ASSERT_TOP(a_no_root_zero, vf_q && (cls_q == qes_pkg::CLS_INF || cls_q == qes_pkg::CLS_NONE) |-> (r1_q == 32'd0) && (r2_q == 32'd0) && !sat_q, "class without roots carries a root")
  `ASSERT_TOP(a_one_root_second_zero, vf_q && (cls_q == qes_pkg::CLS_ONE) |-> (r2_q == 32'd0), "single root word carries a second root")
  `ASSERT_TOP(a_sat_needs_root, vf_q && sat_q |-> (cls_q == qes_pkg::CLS_ONE || cls_q == qes_pkg::CLS_TWO), "saturation flagged without a root")
endmodule
`default_nettype wire
